// ===== rtl/energy_voice_activity_detector_core_macros.svh =====
// Assertion macros for the energy voice activity detector core.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_CORE_MACROS_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define EVAD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("evad: same-cycle check failed");
// next-cycle implication
`define EVAD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("evad: next-cycle check failed");
`else
`define EVAD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define EVAD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/evad_pkg.sv =====
package evad_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int POS_W      = 48;
   localparam int DUR_W      = 20;
   localparam int THR_W      = 15;
   localparam int HOLD_W     = 20;
   localparam int PRE_W      = 20;
   localparam int MAXSEG_W   = 24;
   localparam int SIL_W      = 24;
   localparam int SEG_W      = 25;
   localparam int DEC_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam int MAX_CHUNK  = 4096;
   localparam int CNT_W      = $clog2(MAX_CHUNK + 1);
   localparam int SQ_W       = 2 * SAMPLE_W - 1;
   localparam int ENERGY_W   = SQ_W + CNT_W - 1;
   localparam int THR_SQ_W   = 2 * THR_W;
   localparam int REF_W      = THR_SQ_W + CNT_W;
   localparam int BACK_W     = PRE_W + 1;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 96;

   localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = THR_SQ_W'(328 * 328);
   localparam logic [HOLD_W-1:0]   HOLD_RESET   = HOLD_W'(8000);
   localparam logic [PRE_W-1:0]    PRE_RESET    = PRE_W'(4800);
   localparam logic [MAXSEG_W-1:0] MAXSEG_RESET = MAXSEG_W'(480000);
   localparam logic [SIL_W-1:0]    SIL_MAX      = '1;
   localparam logic [SEG_W-1:0]    SEG_MAX      = '1;

   typedef enum logic [DEC_W-1:0] {
      DEC_NONE     = 2'd0,
      DEC_ONSET    = 2'd1,
      DEC_DISPATCH = 2'd2
   } decision_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD   = 2'd0,
      CSR_HOLD        = 2'd1,
      CSR_PREROLL     = 2'd2,
      CSR_MAX_SEGMENT = 2'd3
   } csr_index_type;

   // controller -> datapath
   typedef struct packed {
      logic take;
      logic square;
      logic accum;
      logic prep;
      logic compare;
      logic decide;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic chunk_end;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/evad_ctrl.sv =====
module evad_ctrl import evad_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IN,
      S_SQUARE,
      S_ACCUM,
      S_PREP,
      S_COMPARE,
      S_DECIDE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IN:      if (req_tvalid) state_in = S_SQUARE;
         S_SQUARE:  state_in = S_ACCUM;
         S_ACCUM:   state_in = status.chunk_end ? S_PREP : S_IN;
         S_PREP:    state_in = S_COMPARE;
         S_COMPARE: state_in = S_DECIDE;
         S_DECIDE:  if (status.out_free) state_in = S_IN;
         default:   state_in = S_IN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IN;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IN);
      end
   end

   assign req_tready  = ready_ff;
   assign cmd.take    = ready_ff && req_tvalid;
   assign cmd.square  = (state_ff == S_SQUARE);
   assign cmd.accum   = (state_ff == S_ACCUM);
   assign cmd.prep    = (state_ff == S_PREP);
   assign cmd.compare = (state_ff == S_COMPARE);
   assign cmd.decide  = (state_ff == S_DECIDE) && status.out_free;

endmodule

// ===== rtl/evad_datapath.sv =====
module evad_datapath import evad_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [SAMPLE_W-1:0]   sample,
   input  logic                  chunk_end,
   input  logic [POS_W-1:0]      write_position,
   input  logic [DUR_W-1:0]      chunk_duration,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DEC_W-1:0]      decision,
   output logic [POS_W-1:0]      segment_start,
   output logic [POS_W-1:0]      segment_end
);

   // config
   logic [THR_SQ_W-1:0] thr_sq_ff;
   logic [HOLD_W-1:0]   hold_ff;
   logic [PRE_W-1:0]    preroll_ff;
   logic [MAXSEG_W-1:0] maxseg_ff;
   logic [THR_W-1:0]    thr_wr;
   logic [THR_SQ_W-1:0] thr_sq_in;

   // captured item
   logic [SAMPLE_W-1:0] smp_ff;
   logic                end_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [DUR_W-1:0]    dur_ff;

   // accumulation
   logic [SAMPLE_W-1:0]   mag;
   logic [2*SAMPLE_W-1:0] sq_full;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [ENERGY_W-1:0]   energy_ff, energy_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  room;

   // chunk-end evaluation
   logic [REF_W-1:0]  ref_ff, ref_in;
   logic [BACK_W-1:0] back_ff, back_in;
   logic              loud_ff, quiet_ff;
   logic [POS_W:0]    diff;
   logic [POS_W-1:0]  cand_ff, cand_in;
   logic [SEG_W:0]    seg_add;
   logic [SIL_W:0]    sil_add;
   logic [SEG_W-1:0]  seg_sum_ff, seg_sum_in;
   logic [SIL_W-1:0]  sil_sum_ff, sil_sum_in;

   // detector state
   logic             active_ff, active_in;
   logic [SIL_W-1:0] sil_ff, sil_in;
   logic [SEG_W-1:0] seg_ff, seg_in;
   logic [POS_W-1:0] origin_ff, origin_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   decision_type     out_dec_ff, dec_in;
   logic [POS_W-1:0] out_start_ff, start_in;
   logic [POS_W-1:0] out_stop_ff, stop_in;

   assign thr_wr    = csr_wdata[THR_W-1:0];
   assign thr_sq_in = thr_wr * thr_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_sq_ff  <= THR_SQ_RESET;
         hold_ff    <= HOLD_RESET;
         preroll_ff <= PRE_RESET;
         maxseg_ff  <= MAXSEG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD:   thr_sq_ff  <= thr_sq_in;
            CSR_HOLD:        hold_ff    <= csr_wdata[HOLD_W-1:0];
            CSR_PREROLL:     preroll_ff <= csr_wdata[PRE_W-1:0];
            CSR_MAX_SEGMENT: maxseg_ff  <= csr_wdata[MAXSEG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         smp_ff <= sample;
         end_ff <= chunk_end;
         pos_ff <= write_position;
         dur_ff <= chunk_duration;
      end
   end

   // |-32768| = 32768 still fits in the unsigned magnitude
   assign mag     = smp_ff[SAMPLE_W-1] ? (~smp_ff + SAMPLE_W'(1)) : smp_ff;
   assign sq_full = mag * mag;
   assign sq_in   = sq_full[SQ_W-1:0];

   // samples past MAX_CHUNK are dropped
   assign room      = (count_ff < CNT_W'(MAX_CHUNK));
   assign energy_in = energy_ff + ENERGY_W'(sq_ff);
   assign count_in  = count_ff + CNT_W'(1);

   assign ref_in  = thr_sq_ff * count_ff;
   assign back_in = BACK_W'(count_ff) + BACK_W'(preroll_ff);

   assign diff       = {1'b0, pos_ff} - (POS_W + 1)'(back_ff);
   assign cand_in    = diff[POS_W] ? '0 : diff[POS_W-1:0];
   assign seg_add    = (SEG_W + 1)'(seg_ff) + (SEG_W + 1)'(dur_ff);
   assign sil_add    = (SIL_W + 1)'(sil_ff) + (SIL_W + 1)'(dur_ff);
   assign seg_sum_in = seg_add[SEG_W] ? SEG_MAX : seg_add[SEG_W-1:0];
   assign sil_sum_in = sil_add[SIL_W] ? SIL_MAX : sil_add[SIL_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.square) sq_ff <= sq_in;
      if (cmd.prep) begin
         ref_ff  <= ref_in;
         back_ff <= back_in;
      end
      if (cmd.compare) begin
         loud_ff    <= (energy_ff > ref_ff);
         quiet_ff   <= (energy_ff < ref_ff);
         cand_ff    <= cand_in;
         seg_sum_ff <= seg_sum_in;
         sil_sum_ff <= sil_sum_in;
      end
   end

   always_comb begin
      active_in = active_ff;
      sil_in    = sil_ff;
      seg_in    = seg_ff;
      origin_in = origin_ff;
      dec_in    = DEC_NONE;
      start_in  = '0;
      stop_in   = '0;
      if (!active_ff) begin
         if (loud_ff) begin
            active_in = 1'b1;
            dec_in    = DEC_ONSET;
            origin_in = cand_ff;
            start_in  = cand_ff;
            sil_in    = '0;
            seg_in    = SEG_W'(dur_ff);
         end
      end else begin
         seg_in = seg_sum_ff;
         if (quiet_ff) begin
            sil_in = sil_sum_ff;
            if (sil_sum_ff >= SIL_W'(hold_ff)) begin
               active_in = 1'b0;
               dec_in    = DEC_DISPATCH;
               start_in  = origin_ff;
               stop_in   = pos_ff;
               origin_in = pos_ff;
               sil_in    = '0;
               seg_in    = '0;
            end
         end else begin
            // level at or above threshold keeps the segment alive
            sil_in = '0;
            if (seg_sum_ff >= SEG_W'(maxseg_ff)) begin
               dec_in    = DEC_DISPATCH;
               start_in  = origin_ff;
               stop_in   = pos_ff;
               origin_in = pos_ff;
               seg_in    = '0;
            end
         end
      end
   end

   assign out_valid_in = cmd.decide ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff    <= '0;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         sil_ff       <= '0;
         seg_ff       <= '0;
         origin_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd.accum && room) begin
            energy_ff <= energy_in;
            count_ff  <= count_in;
         end
         if (cmd.decide) begin
            energy_ff <= '0;
            count_ff  <= '0;
            active_ff <= active_in;
            sil_ff    <= sil_in;
            seg_ff    <= seg_in;
            origin_ff <= origin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         out_dec_ff   <= dec_in;
         out_start_ff <= start_in;
         out_stop_ff  <= stop_in;
      end
   end

   assign status.chunk_end = end_ff;
   assign status.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign decision      = out_dec_ff;
   assign segment_start = out_start_ff;
   assign segment_end   = out_stop_ff;

endmodule

// ===== rtl/energy_voice_activity_detector_core.sv =====
// Energy voice activity detector. Audio samples (signed Q1.15) enter one item at
// a time on req_; req_tlast marks the last sample of a chunk, whose item also
// carries the absolute write position and the chunk duration in 16 kHz sample
// periods. The core sums squared samples (the first MAX_CHUNK of a chunk only)
// and at chunk end compares the chunk energy with threshold^2 * count, tracks
// the idle/speech state with hold-time hangover and a max-segment limit, and
// returns exactly one result item per chunk on rsp_: decision none, speech
// onset (start = position - count - pre-roll, floored at zero) or dispatch
// (start and end of the segment). Samples that do not end a chunk give no
// result. A plain sample passes capture, the squaring multiplier and the
// accumulator; a chunk-end item adds the threshold-product multiply, compare
// and decision steps, and the decision step may wait for the single result
// register to drain. Registers are written through csr_ while the core is
// idle; the user must keep to this, as the block does not enforce it. A
// threshold write is squared on the way in and stored as threshold^2 at the
// write edge. Reset is synchronous and restores all register defaults.
`include "energy_voice_activity_detector_core_macros.svh"

module energy_voice_activity_detector_core import evad_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // sample items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // sample[15:0], write_position[63:16],
                                             // chunk_duration[83:64], zero pad
   input  logic                  req_tlast,  // chunk_end
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // segment_start[47:0], segment_end[95:48]
   output logic [DEC_W-1:0]      rsp_tuser,  // decision[1:0]
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type          cmd;
   status_type       status;
   logic [POS_W-1:0] seg_start;
   logic [POS_W-1:0] seg_end;

   // sequencer: one item at a time through the datapath steps
   evad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // accumulator, chunk decision, state and result register
   evad_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .sample         (req_tdata[SAMPLE_W-1:0]),
      .chunk_end      (req_tlast),
      .write_position (req_tdata[SAMPLE_W+POS_W-1:SAMPLE_W]),
      .chunk_duration (req_tdata[SAMPLE_W+POS_W+DUR_W-1:SAMPLE_W+POS_W]),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .decision       (rsp_tuser),
      .segment_start  (seg_start),
      .segment_end    (seg_end)
   );

   assign rsp_tdata = {seg_end, seg_start};

   // one item in flight: an accepted sample closes the input until it is done
   `EVAD_ASSERT_NXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   // a decision always lands in the result register
   `EVAD_ASSERT_NXT(a_decide_shows, clock, reset, cmd.decide, rsp_tvalid)
   // no-event results carry zero positions
   `EVAD_ASSERT_IMP(a_none_zero, clock, reset, rsp_tvalid && (rsp_tuser == DEC_NONE), rsp_tdata == '0)
   // only defined decision codes leave the core
   `EVAD_ASSERT_IMP(a_code_legal, clock, reset, rsp_tvalid, rsp_tuser <= DEC_DISPATCH)

endmodule
